FILE: sv/wwsc_pkg.sv
`default_nettype none

package wwsc_pkg;

  localparam int LINE_WIDTH = 20;
  localparam int RING_LINES = 32;
  localparam int WORD_CAP   = LINE_WIDTH + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam int KIND_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int RCOL_W   = 5;
  localparam int ROWS_W   = 6;
  localparam int TOP_W    = 5;
  localparam int HELD_W   = 6;
  localparam int CURLN_W  = 5;
  localparam int CURSOR_W = 5;

  localparam int COL_W   = $clog2(LINE_WIDTH + 1);
  localparam int IDX_W   = $clog2(RING_LINES);
  localparam int CNT_W   = $clog2(RING_LINES + 1);
  localparam int WL_W    = $clog2(WORD_CAP + 1);
  localparam int BUF_W   = $clog2(WORD_CAP);
  localparam int STORE_DEPTH = RING_LINES * LINE_WIDTH;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);

  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

  localparam logic [KIND_W-1:0] KIND_TEXT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEWLINE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UP      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DOWN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd5;

  localparam logic [ROWS_W-1:0] VISIBLE_ROWS_RESET = 6'd8;

  typedef enum logic [2:0] {
    OP_TEXT,
    OP_SPACE,
    OP_NEWLINE,
    OP_UP,
    OP_DOWN,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic              eos;
    logic [ROW_W-1:0]  row;
    logic [RCOL_W-1:0] col;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/word_wrap_scrollback_console_top.sv
`default_nettype none

// channel   handshake                      payload
// input     push / full                    kind, char_code, end_of_string, read_row, read_col
// result    empty / pop                    read_char, window_top, lines_held, current_line,
//                                          cursor_column, view_moved
// config    psel, penable, pwrite, pready  paddr, pwdata, prdata (visible_rows at 0)
//
// a byte joining the pending word or written straight to the line, a scroll, clear,
// cell read or unused kind goes from idle straight to done; a byte, space or newline
// that flushes the pending word passes through fit, the cell state once per buffered
// byte, tail and done; a space or newline after a long committed word, tail and done
// reset clears all control state at once; per-line fill counts guard the line store
// a 2-entry queue takes input while the back works; the back stalls while the result waits
module word_wrap_scrollback_console_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [wwsc_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [wwsc_pkg::CHAR_W-1:0]       char_code_i,
  input  wire logic                              end_of_string_i,
  input  wire logic [wwsc_pkg::ROW_W-1:0]        read_row_i,
  input  wire logic [wwsc_pkg::RCOL_W-1:0]       read_col_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [wwsc_pkg::CHAR_W-1:0]            read_char_o,
  output logic [wwsc_pkg::TOP_W-1:0]             window_top_o,
  output logic [wwsc_pkg::HELD_W-1:0]            lines_held_o,
  output logic [wwsc_pkg::CURLN_W-1:0]           current_line_o,
  output logic [wwsc_pkg::CURSOR_W-1:0]          cursor_column_o,
  output logic                                   view_moved_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam logic REG_VISIBLE_ROWS = 1'b0;

  logic [wwsc_pkg::ROWS_W-1:0] visible_rows_q;
  logic                        cfg_write;
  logic                        cmd_valid;
  logic                        cmd_pop;
  wwsc_pkg::cmd_t              cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_VISIBLE_ROWS);
  assign prdata    = (paddr[2] == REG_VISIBLE_ROWS) ? 32'(visible_rows_q) : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visible_rows_q <= wwsc_pkg::VISIBLE_ROWS_RESET;
    end else if (cfg_write) begin
      visible_rows_q <= pwdata[wwsc_pkg::ROWS_W-1:0];
    end
  end

  wwsc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .kind_i          (kind_i),
    .char_code_i     (char_code_i),
    .end_of_string_i (end_of_string_i),
    .read_row_i      (read_row_i),
    .read_col_i      (read_col_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  wwsc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .visible_rows_i  (visible_rows_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .empty           (empty),
    .pop             (pop),
    .read_char_o     (read_char_o),
    .window_top_o    (window_top_o),
    .lines_held_o    (lines_held_o),
    .current_line_o  (current_line_o),
    .cursor_column_o (cursor_column_o),
    .view_moved_o    (view_moved_o)
  );

endmodule

`default_nettype wire

FILE: sv/wwsc_ram.sv
`default_nettype none

module wwsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 640
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/wwsc_front.sv
`default_nettype none

module wwsc_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [wwsc_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [wwsc_pkg::CHAR_W-1:0]      char_code_i,
  input  wire logic                             end_of_string_i,
  input  wire logic [wwsc_pkg::ROW_W-1:0]       read_row_i,
  input  wire logic [wwsc_pkg::RCOL_W-1:0]      read_col_i,
  output logic                                  cmd_valid_o,
  output wwsc_pkg::cmd_t                        cmd_o,
  input  wire logic                             cmd_pop_i
);

  localparam int DEPTH = wwsc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCNT_W = $clog2(DEPTH + 1);

  wwsc_pkg::cmd_t     cls;
  wwsc_pkg::cmd_t     queue_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               push_acc;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : PTR_W'(int'(p) + 1);
  endfunction

  always_comb begin
    cls     = '0;
    cls.ch  = char_code_i;
    cls.row = read_row_i;
    cls.col = read_col_i;
    unique case (kind_i)
      wwsc_pkg::KIND_TEXT: begin
        if (char_code_i == wwsc_pkg::NEWLINE_CODE) begin
          cls.op = wwsc_pkg::OP_NEWLINE;
        end else if (char_code_i == wwsc_pkg::SPACE_CODE) begin
          cls.op = wwsc_pkg::OP_SPACE;
        end else begin
          cls.op  = wwsc_pkg::OP_TEXT;
          cls.eos = end_of_string_i;
        end
      end
      wwsc_pkg::KIND_NEWLINE: cls.op = wwsc_pkg::OP_NEWLINE;
      wwsc_pkg::KIND_UP:      cls.op = wwsc_pkg::OP_UP;
      wwsc_pkg::KIND_DOWN:    cls.op = wwsc_pkg::OP_DOWN;
      wwsc_pkg::KIND_CLEAR:   cls.op = wwsc_pkg::OP_CLEAR;
      wwsc_pkg::KIND_READ:    cls.op = wwsc_pkg::OP_READ;
      default:                cls.op = wwsc_pkg::OP_NOP;
    endcase
  end

  assign full        = (int'(count_q) == DEPTH);
  assign push_acc    = push && !full;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_acc ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_acc && !cmd_pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_acc && cmd_pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      queue_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: sv/wwsc_back.sv
`default_nettype none

module wwsc_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [wwsc_pkg::ROWS_W-1:0]    visible_rows_i,
  input  wire logic                           cmd_valid_i,
  input  wire wwsc_pkg::cmd_t                 cmd_i,
  output logic                                cmd_pop_o,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [wwsc_pkg::CHAR_W-1:0]         read_char_o,
  output logic [wwsc_pkg::TOP_W-1:0]          window_top_o,
  output logic [wwsc_pkg::HELD_W-1:0]         lines_held_o,
  output logic [wwsc_pkg::CURLN_W-1:0]        current_line_o,
  output logic [wwsc_pkg::CURSOR_W-1:0]       cursor_column_o,
  output logic                                view_moved_o
);

  localparam int LW     = wwsc_pkg::LINE_WIDTH;
  localparam int RL     = wwsc_pkg::RING_LINES;
  localparam int COL_W  = wwsc_pkg::COL_W;
  localparam int IDX_W  = wwsc_pkg::IDX_W;
  localparam int CNT_W  = wwsc_pkg::CNT_W;
  localparam int WL_W   = wwsc_pkg::WL_W;
  localparam int BUF_W  = wwsc_pkg::BUF_W;
  localparam int ADDR_W = wwsc_pkg::ADDR_W;
  localparam int CHAR_W = wwsc_pkg::CHAR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIT,
    S_CELL,
    S_TAIL,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    TAIL_KEEP,
    TAIL_SPACE,
    TAIL_NEWLINE
  } tail_e;

  state_e             state_q, state_d;
  tail_e              tail_q, tail_d;
  logic [IDX_W-1:0]   top_q, top_d;
  logic [CNT_W-1:0]   held_q, held_d;
  logic [IDX_W-1:0]   wi_q, wi_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [WL_W-1:0]    wl_q, wl_d;
  logic [WL_W-1:0]    k_q, k_d;
  logic               committed_q, committed_d;
  logic               commit_after_q, commit_after_d;
  logic               moved_q, moved_d;
  logic               is_read_q, is_read_d;
  logic               hit_q, hit_d;
  logic [COL_W-1:0]   fill_q [RL];
  logic [CHAR_W-1:0]  buf_q [wwsc_pkg::WORD_CAP];
  logic               out_valid_q;

  logic [CNT_W-1:0]   rows;
  logic [IDX_W-1:0]   nl_wi, nl_top;
  logic [CNT_W-1:0]   nl_held;
  logic [IDX_W-1:0]   rd_idx, oldest, bottom;
  logic               do_put, do_nl, nl_taken, buf_we, fill_we, fill_clr, out_load;
  logic [CHAR_W-1:0]  put_char;
  logic [COL_W-1:0]   col_base, fill_val;
  logic [IDX_W-1:0]   fill_idx;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr, ram_waddr;
  logic [CHAR_W-1:0]  ram_rdata;
  logic [CHAR_W-1:0]  read_val;

  function automatic logic [IDX_W-1:0] wrap_idx(input int s);
    return IDX_W'((s >= RL) ? s - RL : s);
  endfunction

  always_comb begin
    if (visible_rows_i == '0) begin
      rows = CNT_W'(1);
    end else if (int'(visible_rows_i) > RL) begin
      rows = CNT_W'(RL);
    end else begin
      rows = CNT_W'(visible_rows_i);
    end
  end

  // next-line advance of the ring from the current state
  always_comb begin
    nl_wi = wrap_idx(int'(wi_q) + 1);
    if (int'(held_q) < RL) begin
      nl_held = held_q + CNT_W'(1);
      nl_top  = top_q;
    end else begin
      nl_held = held_q;
      nl_top  = wrap_idx(int'(top_q) + 1);
    end
    if (nl_held >= rows) begin
      nl_top = wrap_idx(int'(nl_wi) + 1 + RL - int'(rows));
    end
  end

  assign rd_idx = wrap_idx(int'(top_q) + int'(cmd_i.row));
  assign oldest = wrap_idx(int'(wi_q) + 1 + RL - int'(held_q));
  assign bottom = wrap_idx(int'(top_q) + int'(rows) - 1);

  always_comb begin
    state_d        = state_q;
    tail_d         = tail_q;
    top_d          = top_q;
    held_d         = held_q;
    wi_d           = wi_q;
    col_d          = col_q;
    wl_d           = wl_q;
    k_d            = k_q;
    committed_d    = committed_q;
    commit_after_d = commit_after_q;
    moved_d        = moved_q;
    is_read_d      = is_read_q;
    hit_d          = hit_q;
    cmd_pop_o      = 1'b0;
    do_put         = 1'b0;
    do_nl          = 1'b0;
    put_char       = cmd_i.ch;
    buf_we         = 1'b0;
    fill_clr       = 1'b0;
    fill_we        = 1'b0;
    fill_idx       = wi_q;
    fill_val       = '0;
    col_base       = col_q;
    nl_taken       = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    ram_waddr      = '0;
    out_load       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          moved_d   = 1'b0;
          is_read_d = 1'b0;
          hit_d     = 1'b0;
          state_d   = S_DONE;
          unique case (cmd_i.op)
            wwsc_pkg::OP_TEXT: begin
              if (committed_q) begin
                do_put = 1'b1;
                if (cmd_i.eos) begin
                  committed_d = 1'b0;
                  wl_d        = '0;
                end
              end else begin
                buf_we = 1'b1;
                wl_d   = wl_q + WL_W'(1);
                if (int'(wl_q) + 1 >= wwsc_pkg::WORD_CAP) begin
                  tail_d         = TAIL_KEEP;
                  commit_after_d = !cmd_i.eos;
                  state_d        = S_FIT;
                end else if (cmd_i.eos) begin
                  tail_d         = TAIL_KEEP;
                  commit_after_d = 1'b0;
                  state_d        = S_FIT;
                end
              end
            end
            wwsc_pkg::OP_SPACE: begin
              tail_d  = TAIL_SPACE;
              state_d = committed_q ? S_TAIL : S_FIT;
            end
            wwsc_pkg::OP_NEWLINE: begin
              tail_d  = TAIL_NEWLINE;
              state_d = committed_q ? S_TAIL : S_FIT;
            end
            wwsc_pkg::OP_UP: begin
              if (held_q > rows && top_q != oldest) begin
                top_d   = wrap_idx(int'(top_q) + RL - 1);
                moved_d = 1'b1;
              end
            end
            wwsc_pkg::OP_DOWN: begin
              if (bottom != wi_q) begin
                top_d   = wrap_idx(int'(top_q) + 1);
                moved_d = 1'b1;
              end
            end
            wwsc_pkg::OP_CLEAR: begin
              fill_clr    = 1'b1;
              top_d       = '0;
              held_d      = CNT_W'(1);
              wi_d        = '0;
              col_d       = '0;
              wl_d        = '0;
              committed_d = 1'b0;
            end
            wwsc_pkg::OP_READ: begin
              is_read_d = 1'b1;
              hit_d     = (int'(cmd_i.col) < int'(fill_q[rd_idx])) && (int'(cmd_i.col) < LW);
              ram_re    = hit_d;
              ram_raddr = ADDR_W'(int'(rd_idx) * LW + int'(cmd_i.col));
            end
            default: begin
            end
          endcase
        end
      end
      S_FIT: begin
        if (col_q != '0 && int'(col_q) + int'(wl_q) > LW) begin
          do_nl = 1'b1;
        end
        k_d     = '0;
        state_d = (wl_q == '0) ? S_TAIL : S_CELL;
      end
      S_CELL: begin
        do_put   = 1'b1;
        put_char = buf_q[k_q[BUF_W-1:0]];
        k_d      = k_q + WL_W'(1);
        if (k_d == wl_q) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        wl_d    = '0;
        state_d = S_DONE;
        unique case (tail_q)
          TAIL_KEEP: committed_d = commit_after_q;
          TAIL_SPACE: begin
            committed_d = 1'b0;
            put_char    = wwsc_pkg::SPACE_CODE;
            do_put      = (int'(col_q) < LW);
          end
          TAIL_NEWLINE: begin
            committed_d = 1'b0;
            do_nl       = 1'b1;
          end
          default: committed_d = 1'b0;
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || pop) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    nl_taken = do_nl || (do_put && int'(col_q) >= LW);
    if (nl_taken) begin
      wi_d     = nl_wi;
      held_d   = nl_held;
      top_d    = nl_top;
      col_d    = '0;
      col_base = '0;
      fill_we  = 1'b1;
      fill_idx = nl_wi;
      fill_val = '0;
    end
    if (do_put) begin
      col_d     = col_base + COL_W'(1);
      fill_we   = 1'b1;
      fill_idx  = wi_d;
      fill_val  = col_d;
      ram_waddr = ADDR_W'(int'(wi_d) * LW + int'(col_base));
    end
  end

  always_comb begin
    read_val = 8'h00;
    if (is_read_q) begin
      read_val = (hit_q && ram_rdata != 8'h00) ? ram_rdata : wwsc_pkg::SPACE_CODE;
    end
  end

  assign empty = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      tail_q          <= TAIL_KEEP;
      top_q           <= '0;
      held_q          <= CNT_W'(1);
      wi_q            <= '0;
      col_q           <= '0;
      wl_q            <= '0;
      k_q             <= '0;
      committed_q     <= 1'b0;
      commit_after_q  <= 1'b0;
      moved_q         <= 1'b0;
      is_read_q       <= 1'b0;
      hit_q           <= 1'b0;
      out_valid_q     <= 1'b0;
      read_char_o     <= '0;
      window_top_o    <= '0;
      lines_held_o    <= '0;
      current_line_o  <= '0;
      cursor_column_o <= '0;
      view_moved_o    <= 1'b0;
      for (int i = 0; i < RL; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q        <= state_d;
      tail_q         <= tail_d;
      top_q          <= top_d;
      held_q         <= held_d;
      wi_q           <= wi_d;
      col_q          <= col_d;
      wl_q           <= wl_d;
      k_q            <= k_d;
      committed_q    <= committed_d;
      commit_after_q <= commit_after_d;
      moved_q        <= moved_d;
      is_read_q      <= is_read_d;
      hit_q          <= hit_d;
      if (fill_clr) begin
        for (int i = 0; i < RL; i++) begin
          fill_q[i] <= '0;
        end
      end else if (fill_we) begin
        fill_q[fill_idx] <= fill_val;
      end
      if (out_load) begin
        out_valid_q     <= 1'b1;
        read_char_o     <= read_val;
        window_top_o    <= wwsc_pkg::TOP_W'(top_q);
        lines_held_o    <= wwsc_pkg::HELD_W'(held_q);
        current_line_o  <= wwsc_pkg::CURLN_W'(wi_q);
        cursor_column_o <= wwsc_pkg::CURSOR_W'(col_q);
        view_moved_o    <= moved_q;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_q[wl_q[BUF_W-1:0]] <= cmd_i.ch;
    end
  end

  wwsc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (wwsc_pkg::STORE_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (do_put),
    .waddr_i (ram_waddr),
    .wdata_i (put_char),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import wwsc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [2:0] VISIBLE_ROWS_ADDR = 3'd0;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 125;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic              eos;
    logic [ROW_W-1:0]  row;
    logic [RCOL_W-1:0] col;
  } console_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   read_char;
    logic [TOP_W-1:0]    window_top;
    logic [HELD_W-1:0]   lines_held;
    logic [CURLN_W-1:0]  current_line;
    logic [CURSOR_W-1:0] cursor_column;
    logic                view_moved;
  } console_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [KIND_W-1:0] kind_i = '0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic end_of_string_i = 1'b0;
  logic [ROW_W-1:0] read_row_i = '0;
  logic [RCOL_W-1:0] read_col_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CHAR_W-1:0] read_char_o;
  logic [TOP_W-1:0] window_top_o;
  logic [HELD_W-1:0] lines_held_o;
  logic [CURLN_W-1:0] current_line_o;
  logic [CURSOR_W-1:0] cursor_column_o;
  logic view_moved_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  word_wrap_scrollback_console_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .kind_i(kind_i), .char_code_i(char_code_i), .end_of_string_i(end_of_string_i),
    .read_row_i(read_row_i), .read_col_i(read_col_i),
    .empty(empty), .pop(pop),
    .read_char_o(read_char_o), .window_top_o(window_top_o), .lines_held_o(lines_held_o),
    .current_line_o(current_line_o), .cursor_column_o(cursor_column_o),
    .view_moved_o(view_moved_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  console_item_t queued_items[$];
  console_view_t expected_views[$];
  idle_mode_e idle_mode = IDLE_NONE;
  logic item_taken = 1'b0;
  int unsigned items_queued = 0;
  int unsigned mismatch_count = 0;

  // console shadow state
  int unsigned rows_cfg;
  logic [7:0] cell_mem [RING_LINES][LINE_WIDTH];
  int unsigned fill_cnt [RING_LINES];
  int unsigned top_line, held_lines, cur_line, cur_col, pend_len;
  logic [7:0] word_buf [WORD_CAP];
  bit word_done;

  function automatic int unsigned shown_rows();
    if (rows_cfg == 0) return 1;
    if (rows_cfg > RING_LINES) return RING_LINES;
    return rows_cfg;
  endfunction

  function automatic logic [CHAR_W-1:0] rnd_char();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [ROW_W-1:0] rnd_row();
    return ROW_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [RCOL_W-1:0] rnd_col();
    return RCOL_W'($urandom_range(0, 31));
  endfunction

  task automatic wipe_console();
    for (int i = 0; i < RING_LINES; i++) begin
      fill_cnt[i] = 0;
      for (int j = 0; j < LINE_WIDTH; j++) cell_mem[i][j] = '0;
    end
    for (int i = 0; i < WORD_CAP; i++) word_buf[i] = '0;
    top_line = 0;
    held_lines = 1;
    cur_line = 0;
    cur_col = 0;
    pend_len = 0;
    word_done = 1'b0;
  endtask

  task automatic advance_line();
    int unsigned rows;
    rows = shown_rows();
    cur_col = 0;
    cur_line = (cur_line + 1) % RING_LINES;
    fill_cnt[cur_line] = 0;
    if (held_lines < RING_LINES) held_lines++;
    else top_line = (top_line + 1) % RING_LINES;
    if (held_lines >= rows) top_line = (cur_line + 1 + RING_LINES - rows) % RING_LINES;
  endtask

  task automatic put_char(input logic [7:0] c);
    if (cur_col >= LINE_WIDTH) advance_line();
    if (cur_col < LINE_WIDTH) cell_mem[cur_line][cur_col] = c;
    cur_col++;
    fill_cnt[cur_line] = cur_col;
  endtask

  task automatic flush_word();
    if (cur_col > 0 && cur_col + pend_len > LINE_WIDTH) advance_line();
    for (int k = 0; k < pend_len && k < WORD_CAP; k++) put_char(word_buf[k]);
    pend_len = 0;
  endtask

  task automatic close_word();
    if (!word_done) flush_word();
    pend_len = 0;
    word_done = 1'b0;
  endtask

  task automatic console_step(input console_item_t it, output console_view_t res);
    logic [KIND_W-1:0] k;
    int unsigned rows, oldest, bottom, idx;
    k = it.kind;
    rows = shown_rows();
    res = '0;
    if (k == KIND_TEXT && it.ch == NEWLINE_CODE) k = KIND_NEWLINE;
    case (k)
      KIND_TEXT: begin
        if (it.ch == SPACE_CODE) begin
          close_word();
          if (cur_col < LINE_WIDTH) put_char(SPACE_CODE);
        end else begin
          if (word_done) begin
            put_char(it.ch);
          end else begin
            if (pend_len < WORD_CAP) word_buf[pend_len] = it.ch;
            pend_len++;
            if (pend_len >= WORD_CAP) begin
              flush_word();
              word_done = 1'b1;
            end
          end
          if (it.eos) close_word();
        end
      end
      KIND_NEWLINE: begin
        close_word();
        advance_line();
      end
      KIND_UP: begin
        if (held_lines > rows) begin
          oldest = (cur_line + 1 + RING_LINES - held_lines) % RING_LINES;
          if (top_line != oldest) begin
            top_line = (top_line + RING_LINES - 1) % RING_LINES;
            res.view_moved = 1'b1;
          end
        end
      end
      KIND_DOWN: begin
        bottom = (top_line + rows - 1) % RING_LINES;
        if (bottom != cur_line) begin
          top_line = (top_line + 1) % RING_LINES;
          res.view_moved = 1'b1;
        end
      end
      KIND_CLEAR: wipe_console();
      KIND_READ: begin
        idx = (top_line + it.row) % RING_LINES;
        res.read_char = SPACE_CODE;
        if (it.col < fill_cnt[idx] && it.col < LINE_WIDTH) begin
          if (cell_mem[idx][it.col] != '0) res.read_char = cell_mem[idx][it.col];
        end
      end
      default: ;
    endcase
    res.window_top = TOP_W'(top_line);
    res.lines_held = HELD_W'(held_lines);
    res.current_line = CURLN_W'(cur_line);
    res.cursor_column = CURSOR_W'(cur_col);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic enqueue(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] c,
                         input logic e, input logic [ROW_W-1:0] r,
                         input logic [RCOL_W-1:0] cl);
    console_item_t it;
    it = '{k, c, e, r, cl};
    queued_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned goal, len, pick, j;
    logic [7:0] b;
    goal = items_queued + n;
    while (items_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 45) : $urandom_range(1, 10);
        for (j = 0; j < len; j++) begin
          b = rnd_char();
          if ($urandom_range(0, 19) == 0) b = 8'h00;
          if (b == SPACE_CODE || b == NEWLINE_CODE)
            b = 8'h61 + CHAR_W'($urandom_range(0, 25));
          enqueue(KIND_TEXT, b, (j == len - 1) && ($urandom_range(0, 3) == 0),
                  rnd_row(), rnd_col());
        end
        if ($urandom_range(0, 4) != 0)
          enqueue(KIND_TEXT, SPACE_CODE, rnd_bit(), rnd_row(), rnd_col());
      end else if (pick < 60) begin
        if ($urandom_range(0, 1) == 0)
          enqueue(KIND_NEWLINE, rnd_char(), rnd_bit(), rnd_row(), rnd_col());
        else
          enqueue(KIND_TEXT, NEWLINE_CODE, rnd_bit(), rnd_row(), rnd_col());
      end else if (pick < 68) begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++)
          enqueue(KIND_UP, rnd_char(), rnd_bit(), rnd_row(), rnd_col());
      end else if (pick < 76) begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++)
          enqueue(KIND_DOWN, rnd_char(), rnd_bit(), rnd_row(), rnd_col());
      end else if (pick < 93) begin
        enqueue(KIND_READ, rnd_char(), rnd_bit(),
                ROW_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 8)),
                RCOL_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, 19)));
      end else if (pick < 94) begin
        enqueue(KIND_CLEAR, rnd_char(), rnd_bit(), rnd_row(), rnd_col());
      end else if (pick < 97) begin
        len = $urandom_range(1, 3);
        for (j = 0; j < len; j++)
          enqueue(KIND_TEXT, SPACE_CODE, rnd_bit(), rnd_row(), rnd_col());
      end else begin
        enqueue(KIND_W'($urandom_range(0, 7)), rnd_char(), rnd_bit(), rnd_row(), rnd_col());
      end
    end
  endtask

  task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= VISIBLE_ROWS_ADDR;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    if (wr) rows_cfg = wdata[ROWS_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_quiet();
    @(posedge clk_i);
    while (queued_items.size() != 0 || expected_views.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[word_wrap_scrollback_console_top] ERROR");
    $finish;
  end

  // input side: drive at the falling edge, hold until the transaction is taken
  always @(negedge clk_i) begin : feed
    logic hold;
    bit idle;
    int unsigned r;
    hold = push && !item_taken;
    r = $urandom_range(0, 99);
    idle = (idle_mode == IDLE_SENDER && r < 64) || (idle_mode == IDLE_BOTH && r < 7);
    if (item_taken) queued_items.delete(0);
    if (!hold) begin
      if (rst_ni && queued_items.size() != 0 && !idle) begin
        push <= 1'b1;
        kind_i <= queued_items[0].kind;
        char_code_i <= queued_items[0].ch;
        end_of_string_i <= queued_items[0].eos;
        read_row_i <= queued_items[0].row;
        read_col_i <= queued_items[0].col;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drain
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!rst_ni) pop <= 1'b0;
    else if (idle_mode == IDLE_RECEIVER) pop <= (r >= 64);
    else if (idle_mode == IDLE_BOTH) pop <= (r >= 7);
    else pop <= 1'b1;
  end

  always @(posedge clk_i) begin : take
    console_item_t it;
    console_view_t v;
    item_taken <= rst_ni && push && !full;
    if (rst_ni && push && !full) begin
      it = '{kind_i, char_code_i, end_of_string_i, read_row_i, read_col_i};
      console_step(it, v);
      expected_views.push_back(v);
    end
  end

  always @(posedge clk_i) begin : watch
    console_view_t v;
    if (rst_ni && pop && !empty) begin
      if (expected_views.size() == 0) begin
        $display("%0t unexpected result transaction: expected none actual read_char %0d",
                 $time, read_char_o);
        mismatch_count++;
      end else begin
        v = expected_views.pop_front();
        check_field("read_char", v.read_char, read_char_o);
        check_field("window_top", v.window_top, window_top_o);
        check_field("lines_held", v.lines_held, lines_held_o);
        check_field("current_line", v.current_line, current_line_o);
        check_field("cursor_column", v.cursor_column, cursor_column_o);
        check_field("view_moved", v.view_moved, view_moved_o);
      end
    end
  end

  initial begin
    logic [ROWS_W-1:0] row_plan [PHASES];
    logic [31:0] rd;
    row_plan = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd8, 6'd3, 6'd17, 6'd0};
    row_plan[PHASES-1] = ROWS_W'($urandom_range(2, 31));
    wipe_console();
    rows_cfg = VISIBLE_ROWS_RESET;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty cells, both byte extremes, zero byte, newline forms, scrolls,
    // far reads, spare kinds, spaces at column zero, clear
    enqueue(KIND_READ, 8'hff, 1'b1, 5'd0, 5'd0);
    enqueue(KIND_TEXT, 8'h48, 1'b0, 5'd31, 5'd31);
    enqueue(KIND_TEXT, 8'h69, 1'b0, 5'd0, 5'd0);
    enqueue(KIND_TEXT, SPACE_CODE, 1'b0, 5'd0, 5'd0);
    enqueue(KIND_TEXT, 8'h00, 1'b1, 5'd0, 5'd0);
    enqueue(KIND_TEXT, 8'hff, 1'b1, 5'd0, 5'd0);
    enqueue(KIND_TEXT, NEWLINE_CODE, 1'b0, 5'd0, 5'd0);
    enqueue(KIND_NEWLINE, 8'hff, 1'b1, 5'd31, 5'd31);
    enqueue(KIND_READ, 8'h00, 1'b0, 5'd0, 5'd0);
    enqueue(KIND_READ, 8'h00, 1'b0, 5'd0, 5'd3);
    enqueue(KIND_READ, 8'h00, 1'b0, 5'd1, 5'd0);
    enqueue(KIND_UP, 8'h00, 1'b1, 5'd0, 5'd0);
    enqueue(KIND_DOWN, 8'h00, 1'b1, 5'd0, 5'd0);
    enqueue(KIND_UP, 8'hff, 1'b0, 5'd0, 5'd0);
    enqueue(KIND_READ, 8'hff, 1'b1, 5'd31, 5'd31);
    enqueue(KIND_READ, 8'h00, 1'b0, 5'd0, 5'd19);
    enqueue(KIND_SPARE_LO, 8'hff, 1'b1, 5'd31, 5'd31);
    enqueue(KIND_SPARE_HI, 8'h41, 1'b0, 5'd0, 5'd0);
    enqueue(KIND_TEXT, SPACE_CODE, 1'b1, 5'd0, 5'd0);
    enqueue(KIND_TEXT, SPACE_CODE, 1'b0, 5'd0, 5'd0);
    enqueue(KIND_CLEAR, 8'hff, 1'b1, 5'd31, 5'd31);
    enqueue(KIND_READ, 8'h00, 1'b0, 5'd0, 5'd0);
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      apb_transfer(1'b1, {26'd0, row_plan[p]}, rd);
      apb_transfer(1'b0, 32'd0, rd);
      if (rd !== {26'd0, row_plan[p]}) begin
        $display("%0t visible_rows readback expected %0d actual %0d", $time,
                 row_plan[p], rd);
        mismatch_count++;
      end
      @(posedge clk_i);
      idle_mode = idle_mode_e'(p % 4);
      queue_random(PHASE_ITEMS / 2);
      // sender holds off until the block has handed back everything
      wait_quiet();
      queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      wait_quiet();
    end

    if (mismatch_count == 0) begin
      $display("[word_wrap_scrollback_console_top] OK");
    end else begin
      $display("[word_wrap_scrollback_console_top] ERROR");
    end
    $finish;
  end

endmodule
